// File: hw/rtl/i2cm_pkg.sv
// ---------------------------------------------------------------------------
// i2cm_pkg
// shared types and codes for the i2c master bit engine
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

  // request operation codes
  localparam logic [3:0] OP_TICK  = 4'd0;
  localparam logic [3:0] OP_START = 4'd1;
  localparam logic [3:0] OP_STOP  = 4'd2;
  localparam logic [3:0] OP_WRITE = 4'd3;
  localparam logic [3:0] OP_READ  = 4'd4;
  localparam logic [3:0] OP_ACK   = 4'd5;
  localparam logic [3:0] OP_NACK  = 4'd6;
  localparam logic [3:0] OP_WAIT  = 4'd7;
  localparam logic [3:0] OP_PROBE = 4'd8;

  localparam logic [7:0] MSB_MASK = 8'h80;
  localparam logic [7:0] RW_WRITE = 8'h00;

  // sequencer state
  typedef struct packed {
    logic [3:0] cmd;
    logic [5:0] phase;
    logic [7:0] shift;
    logic       scl;
    logic       sda;
    logic       ack;
  } state_t;

  // one request
  typedef struct packed {
    logic [3:0] operation;
    logic [7:0] data_byte;
    logic       sda_in;
    logic       scl_in;
  } req_t;

  // one result
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_bit;
    logic       rejected;
  } res_t;

endpackage

`default_nettype wire

// File: hw/rtl/i2cm_step.sv
// ---------------------------------------------------------------------------
// i2cm_step
// next-state and result logic for one request of the bit engine
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cm_step (
  input  wire i2cm_pkg::state_t st,
  input  wire i2cm_pkg::req_t   req,
  output i2cm_pkg::state_t      st_next,
  output i2cm_pkg::res_t        res
);

  typedef struct packed {
    i2cm_pkg::state_t st;
    logic             last;
  } tick_t;

  function automatic i2cm_pkg::state_t op_begin(input logic [3:0] op,
                                                input i2cm_pkg::state_t s);
    i2cm_pkg::state_t r;
    r = s;
    case (op)
      i2cm_pkg::OP_START: begin r.sda = 1'b1; r.scl = 1'b1; end
      i2cm_pkg::OP_STOP:  begin r.sda = 1'b0; r.scl = 1'b1; end
      i2cm_pkg::OP_WRITE: r.sda = |(s.shift & i2cm_pkg::MSB_MASK);
      i2cm_pkg::OP_READ:  begin r.shift = 8'd0; r.scl = 1'b1; end
      i2cm_pkg::OP_ACK:   r.sda = 1'b0;
      i2cm_pkg::OP_NACK:  r.sda = 1'b1;
      i2cm_pkg::OP_WAIT:  r.sda = 1'b1;
      default: ;
    endcase
    return r;
  endfunction

  function automatic tick_t op_tick(input logic [3:0] op, input logic [5:0] p,
                                    input logic sda, input i2cm_pkg::state_t s);
    tick_t      t;
    logic [9:0] prod;
    logic [4:0] bit_idx;
    logic [4:0] three_b;
    logic [1:0] sub;
    t.st    = s;
    t.last  = 1'b0;
    // divide by three through a reciprocal, exact for phases below 32
    prod    = 10'(p[4:0]) * 10'd11;
    bit_idx = prod[9:5];
    three_b = 5'(bit_idx * 5'd3);
    sub     = 2'(p[4:0] - three_b);
    case (op)
      i2cm_pkg::OP_START: begin
        if (p == 6'd0) t.st.sda = 1'b0;
        else if (p == 6'd1) t.st.scl = 1'b0;
        t.last = (p >= 6'd2);
      end
      i2cm_pkg::OP_STOP: begin
        if (p == 6'd0) t.st.sda = 1'b1;
        t.last = (p >= 6'd1);
      end
      i2cm_pkg::OP_WRITE: begin
        if (sub == 2'd0) begin
          t.st.scl = 1'b1;
        end else if (sub == 2'd1) begin
          t.st.scl = 1'b0;
          if (bit_idx >= 5'd7) t.st.sda = 1'b1;
          t.st.shift = {s.shift[6:0], 1'b0};
        end else begin
          if (bit_idx >= 5'd7) t.last = 1'b1;
          else t.st.sda = s.shift[7];
        end
      end
      i2cm_pkg::OP_READ: begin
        if (!p[0]) begin
          t.st.shift = {s.shift[6:0], sda};
          t.st.scl   = 1'b0;
        end else if (p[5:1] >= 5'd7) begin
          t.last = 1'b1;
        end else begin
          t.st.scl = 1'b1;
        end
      end
      i2cm_pkg::OP_ACK: begin
        if (p == 6'd0) t.st.scl = 1'b1;
        else if (p == 6'd1) t.st.scl = 1'b0;
        else t.st.sda = 1'b1;
        t.last = (p >= 6'd2);
      end
      i2cm_pkg::OP_NACK: begin
        if (p == 6'd0) t.st.scl = 1'b1;
        else if (p == 6'd1) t.st.scl = 1'b0;
        t.last = (p >= 6'd2);
      end
      i2cm_pkg::OP_WAIT: begin
        if (p == 6'd1) begin
          t.st.ack = sda;
          t.st.scl = 1'b0;
        end else if (p == 6'd0) begin
          t.st.scl = 1'b1;
        end
        t.last = (p >= 6'd2);
      end
      default: t.last = 1'b1;
    endcase
    return t;
  endfunction

  // probe chains start, address write, ack check and stop
  function automatic tick_t probe_tick(input logic [5:0] p, input logic sda,
                                       input i2cm_pkg::state_t s);
    tick_t t;
    t = '0;
    if (p < 6'd3) begin
      t = op_tick(i2cm_pkg::OP_START, p, sda, s);
      if (t.last) t.st = op_begin(i2cm_pkg::OP_WRITE, t.st);
      t.last = 1'b0;
    end else if (p < 6'd27) begin
      t = op_tick(i2cm_pkg::OP_WRITE, 6'(p - 6'd3), sda, s);
      if (t.last) t.st = op_begin(i2cm_pkg::OP_WAIT, t.st);
      t.last = 1'b0;
    end else if (p < 6'd30) begin
      t = op_tick(i2cm_pkg::OP_WAIT, 6'(p - 6'd27), sda, s);
      if (t.last) t.st = op_begin(i2cm_pkg::OP_STOP, t.st);
      t.last = 1'b0;
    end else begin
      t = op_tick(i2cm_pkg::OP_STOP, 6'(p - 6'd30), sda, s);
    end
    return t;
  endfunction

  tick_t            tk;
  i2cm_pkg::state_t ns;
  logic             done;
  logic             rej;

  always_comb begin
    ns   = st;
    done = 1'b0;
    rej  = 1'b0;
    tk   = '0;
    if (req.operation == i2cm_pkg::OP_TICK) begin
      if (st.cmd != i2cm_pkg::OP_TICK) begin
        if (st.cmd == i2cm_pkg::OP_PROBE) tk = probe_tick(st.phase, req.sda_in, st);
        else tk = op_tick(st.cmd, st.phase, req.sda_in, st);
        ns = tk.st;
        if (tk.last) begin
          done     = 1'b1;
          ns.cmd   = i2cm_pkg::OP_TICK;
          ns.phase = 6'd0;
        end else begin
          ns.phase = 6'(st.phase + 6'd1);
        end
      end
    end else if (req.operation <= i2cm_pkg::OP_PROBE) begin
      if (st.cmd != i2cm_pkg::OP_TICK) begin
        rej = 1'b1;
      end else if (req.operation == i2cm_pkg::OP_PROBE && !(req.sda_in && req.scl_in)) begin
        // bus not idle: fail at once
        ns.ack = 1'b1;
        done   = 1'b1;
      end else begin
        if (req.operation == i2cm_pkg::OP_WRITE) ns.shift = req.data_byte;
        if (req.operation == i2cm_pkg::OP_PROBE) begin
          ns.shift = req.data_byte | i2cm_pkg::RW_WRITE;
          ns = op_begin(i2cm_pkg::OP_START, ns);
        end else begin
          ns = op_begin(req.operation, ns);
        end
        ns.cmd   = req.operation;
        ns.phase = 6'd0;
      end
    end
  end

  assign st_next       = ns;
  assign res.scl_out   = ns.scl;
  assign res.sda_out   = ns.sda;
  assign res.busy_res  = (ns.cmd != i2cm_pkg::OP_TICK);
  assign res.done_res  = done;
  assign res.read_data = ns.shift;
  assign res.ack_bit   = ns.ack;
  assign res.rejected  = rej;

endmodule

`default_nettype wire

// File: hw/rtl/i2c_master_bit_engine.sv
// ---------------------------------------------------------------------------
// i2c_master_bit_engine
// open-drain i2c master bit sequencer driven by ticks and commands
// ---------------------------------------------------------------------------
// Each request is either one bit-delay tick or a command (start, stop, write
// byte, read byte, ack, nack, wait ack, probe address). A command sets up its
// first drive levels at once; every later tick advances the sequence by one
// phase and updates the scl/sda drive levels. Every request gives exactly one
// result carrying the drive levels, busy/done, the shift byte, the ack flag
// and a rejected flag for commands that arrive while a sequence runs.
// Throughput is one request per clock; a request passes the request register,
// then the phase sequencer into the result register. A full result register
// that is not taken holds the pipeline.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_bit_engine (
  input  wire        clk,
  input  wire        rst,
  // request channel
  input  wire        in_valid,
  output logic       in_ready,
  input  wire  [3:0] operation,
  input  wire  [7:0] data_byte,
  input  wire        sda_in,
  input  wire        scl_in,
  // result channel
  output logic       out_valid,
  input  wire        out_ready,
  output logic       scl_out,
  output logic       sda_out,
  output logic       busy_res,
  output logic       done_res,
  output logic [7:0] read_data,
  output logic       ack_bit,
  output logic       rejected
);

  // request register
  logic             req_valid;
  i2cm_pkg::req_t   req;
  // sequencer state and result register
  i2cm_pkg::state_t st;
  i2cm_pkg::state_t st_next;
  i2cm_pkg::res_t   res_next;
  i2cm_pkg::res_t   res;
  logic             advance;

  // the held request moves on whenever the result slot is free or draining
  assign advance  = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req.operation <= operation;
      req.data_byte <= data_byte;
      req.sda_in    <= sda_in;
      req.scl_in    <= scl_in;
    end
  end

  i2cm_step u_step (
    .st      (st),
    .req     (req),
    .st_next (st_next),
    .res     (res_next)
  );

  // sequencer state only changes when a request is consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      st.cmd   <= i2cm_pkg::OP_TICK;
      st.phase <= 6'd0;
      st.shift <= 8'd0;
      st.scl   <= 1'b1;
      st.sda   <= 1'b1;
      st.ack   <= 1'b1;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign scl_out   = res.scl_out;
  assign sda_out   = res.sda_out;
  assign busy_res  = res.busy_res;
  assign done_res  = res.done_res;
  assign read_data = res.read_data;
  assign ack_bit   = res.ack_bit;
  assign rejected  = res.rejected;

endmodule

`default_nettype wire

// File: bench/i2c_master_bit_engine_tb.sv
// ---------------------------------------------------------------------------
// i2c_master_bit_engine_tb
// self-checking bench for the i2c master bit engine
// ---------------------------------------------------------------------------
// Requests come from a queue that is filled at time zero. A short directed
// part covers the special cases and every command. A longer random part
// follows, mostly whole command sequences with random bus levels, mixed with
// broken sequences and noise. A clocked driver sends the requests with random
// gaps. A clocked monitor compares every result with the bus model's
// prediction. The receiver stalls at random and holds off once for a long
// stretch. The sender pauses once until every result is back.
`timescale 1ns / 1ps

module i2c_master_bit_engine_tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int TAIL_CYCLES  = 10;
  localparam int RANDOM_REQS  = 880;
  localparam int LONG_HOLD    = 300;
  localparam int CALM_TAIL    = 100;
  localparam int MAX_PRINTS   = 50;
  localparam logic [3:0] CMD_IDLE = 4'd0;

  typedef struct {
    logic [3:0] op;
    logic [7:0] data;
    logic       sda;
    logic       scl;
    bit         drain_first;
  } pending_req_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [3:0] operation;
  logic [7:0] data_byte;
  logic       sda_in;
  logic       scl_in;
  logic       out_valid;
  logic       out_ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       ack_bit;
  logic       rejected;

  i2c_master_bit_engine dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .data_byte (data_byte),
    .sda_in    (sda_in),
    .scl_in    (scl_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .scl_out   (scl_out),
    .sda_out   (sda_out),
    .busy_res  (busy_res),
    .done_res  (done_res),
    .read_data (read_data),
    .ack_bit   (ack_bit),
    .rejected  (rejected)
  );

  pending_req_t     pending_reqs[$];
  i2cm_pkg::res_t   due_results[$];

  int cycle_count;
  int sent_count;
  int results_seen;
  int error_count;
  int total_reqs;
  int send_gap;
  int recv_gap;
  int hold_left;
  bit long_hold_done;
  bit req_taken;

  // no idling once the run is close to its end
  wire calm = (sent_count + CALM_TAIL >= total_reqs);

  // bus model state, mirrors the sequencer
  logic [3:0] m_cmd;
  logic [5:0] m_phase;
  logic [7:0] m_shift;
  logic       m_scl;
  logic       m_sda;
  logic       m_ack;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // bus model
  // ---------------------------------------------------------------------

  // drive levels set before the first bit delay of a basic command
  function automatic void drive_first(logic [3:0] op);
    case (op)
      i2cm_pkg::OP_START: begin
        m_sda = 1'b1;
        m_scl = 1'b1;
      end
      i2cm_pkg::OP_STOP: begin
        m_sda = 1'b0;
        m_scl = 1'b1;
      end
      i2cm_pkg::OP_WRITE: m_sda = m_shift[7];
      i2cm_pkg::OP_READ: begin
        m_shift = 8'h00;
        m_scl   = 1'b1;
      end
      i2cm_pkg::OP_ACK:  m_sda = 1'b0;
      i2cm_pkg::OP_NACK: m_sda = 1'b1;
      i2cm_pkg::OP_WAIT: m_sda = 1'b1;
      default: ;
    endcase
  endfunction

  // one bit delay of a basic command at phase p, true on its last delay
  function automatic bit seq_step(logic [3:0] op, int p, logic sda);
    int bit_no = p / 3;
    int sub    = p % 3;
    case (op)
      i2cm_pkg::OP_START: begin
        if (p == 0) m_sda = 1'b0;
        else if (p == 1) m_scl = 1'b0;
        return p >= 2;
      end
      i2cm_pkg::OP_STOP: begin
        if (p == 0) m_sda = 1'b1;
        return p >= 1;
      end
      i2cm_pkg::OP_WRITE: begin
        if (sub == 0) begin
          m_scl = 1'b1;
        end else if (sub == 1) begin
          m_scl = 1'b0;
          // release sda for the ack slot after the last data bit
          if (bit_no >= 7) m_sda = 1'b1;
          m_shift = {m_shift[6:0], 1'b0};
        end else begin
          if (bit_no >= 7) return 1'b1;
          m_sda = (m_shift & i2cm_pkg::MSB_MASK) != 8'h00;
        end
        return 1'b0;
      end
      i2cm_pkg::OP_READ: begin
        if (p % 2 == 0) begin
          m_shift = {m_shift[6:0], sda};
          m_scl   = 1'b0;
          return 1'b0;
        end
        if (p / 2 >= 7) return 1'b1;
        m_scl = 1'b1;
        return 1'b0;
      end
      i2cm_pkg::OP_ACK: begin
        if (p == 0) m_scl = 1'b1;
        else if (p == 1) m_scl = 1'b0;
        else m_sda = 1'b1;
        return p >= 2;
      end
      i2cm_pkg::OP_NACK: begin
        if (p == 0) m_scl = 1'b1;
        else if (p == 1) m_scl = 1'b0;
        return p >= 2;
      end
      i2cm_pkg::OP_WAIT: begin
        if (p == 1) begin
          m_ack = sda;
          m_scl = 1'b0;
        end else if (p == 0) begin
          m_scl = 1'b1;
        end
        return p >= 2;
      end
      default: return 1'b1;
    endcase
  endfunction

  // advance the bus model by one request and form its result
  task automatic predict_bus_step(input logic [3:0] op, input logic [7:0] data,
                                  input logic sda, input logic scl,
                                  output i2cm_pkg::res_t res);
    logic done = 1'b0;
    logic rej  = 1'b0;
    bit   last = 1'b0;
    int   p;
    if (op == i2cm_pkg::OP_TICK) begin
      if (m_cmd != CMD_IDLE) begin
        p = int'(m_phase);
        if (m_cmd == i2cm_pkg::OP_PROBE) begin
          // probe chains start, address write, ack check and stop
          if (p < 3) begin
            if (seq_step(i2cm_pkg::OP_START, p, sda)) drive_first(i2cm_pkg::OP_WRITE);
          end else if (p < 27) begin
            if (seq_step(i2cm_pkg::OP_WRITE, p - 3, sda)) drive_first(i2cm_pkg::OP_WAIT);
          end else if (p < 30) begin
            if (seq_step(i2cm_pkg::OP_WAIT, p - 27, sda)) drive_first(i2cm_pkg::OP_STOP);
          end else begin
            last = seq_step(i2cm_pkg::OP_STOP, p - 30, sda);
          end
        end else begin
          last = seq_step(m_cmd, p, sda);
        end
        if (last) begin
          done    = 1'b1;
          m_cmd   = CMD_IDLE;
          m_phase = '0;
        end else begin
          m_phase = 6'(p + 1);
        end
      end
    end else if (op <= i2cm_pkg::OP_PROBE) begin
      if (m_cmd != CMD_IDLE) begin
        rej = 1'b1;
      end else if (op == i2cm_pkg::OP_PROBE && !(sda && scl)) begin
        // bus not idle: probe fails at once
        m_ack = 1'b1;
        done  = 1'b1;
      end else begin
        if (op == i2cm_pkg::OP_WRITE) m_shift = data;
        if (op == i2cm_pkg::OP_PROBE) begin
          m_shift = data | i2cm_pkg::RW_WRITE;
          drive_first(i2cm_pkg::OP_START);
        end else begin
          drive_first(op);
        end
        m_cmd   = op;
        m_phase = '0;
      end
    end
    // unknown codes fall through untouched
    res.scl_out   = m_scl;
    res.sda_out   = m_sda;
    res.busy_res  = (m_cmd != CMD_IDLE);
    res.done_res  = done;
    res.read_data = m_shift;
    res.ack_bit   = m_ack;
    res.rejected  = rej;
  endtask

  // ---------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTS) $display("ERROR: result %0d: %s", results_seen, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------

  task automatic push_req(input logic [3:0] op, input logic [7:0] data,
                          input logic sda, input logic scl);
    pending_req_t r;
    r.op          = op;
    r.data        = data;
    r.sda         = sda;
    r.scl         = scl;
    r.drain_first = 1'b0;
    pending_reqs.push_back(r);
  endtask

  // bit-delay ticks with random bus levels
  task automatic push_ticks(input int n);
    for (int i = 0; i < n; i++)
      push_req(i2cm_pkg::OP_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // ---------------------------------------------------------------------
  // monitor and request bookkeeping, sampled at the rising edge
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    i2cm_pkg::res_t want_res;
    i2cm_pkg::res_t got_res;
    cycle_count++;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          report_mismatch("result with no request waiting");
        end else begin
          want_res = due_results.pop_front();
          check_field("scl_out",   8'(scl_out),   8'(want_res.scl_out));
          check_field("sda_out",   8'(sda_out),   8'(want_res.sda_out));
          check_field("busy_res",  8'(busy_res),  8'(want_res.busy_res));
          check_field("done_res",  8'(done_res),  8'(want_res.done_res));
          check_field("read_data", read_data,     want_res.read_data);
          check_field("ack_bit",   8'(ack_bit),   8'(want_res.ack_bit));
          check_field("rejected",  8'(rejected),  8'(want_res.rejected));
        end
        results_seen++;
      end
      // request accepted: run the bus model on it
      if (in_valid && in_ready) begin
        predict_bus_step(operation, data_byte, sda_in, scl_in, got_res);
        due_results.push_back(got_res);
        sent_count++;
        req_taken = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // request driver, changes inputs at the falling edge
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    pending_req_t nxt;
    logic         next_valid;
    next_valid = in_valid;
    if (req_taken) begin
      req_taken  = 1'b0;
      next_valid = 1'b0;
      if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 13);
    end
    if (!rst && !next_valid) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_reqs.size() > 0 &&
                   !(pending_reqs[0].drain_first && due_results.size() != 0)) begin
        // a drain-marked request waits until every result is back
        nxt = pending_reqs.pop_front();
        operation  <= nxt.op;
        data_byte  <= nxt.data;
        sda_in     <= nxt.sda;
        scl_in     <= nxt.scl;
        next_valid = 1'b1;
      end
    end
    in_valid <= next_valid;
  end

  // ---------------------------------------------------------------------
  // result receiver, random stalls plus one long hold-off
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!long_hold_done && sent_count >= 400) begin
      // sender keeps offering while the block backs up
      long_hold_done = 1'b1;
      hold_left      = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      recv_gap = $urandom_range(1, 13) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus build, reset and end of run
  // ---------------------------------------------------------------------
  initial begin
    logic [3:0] op;
    logic [7:0] data;
    int         kind;
    int         len;
    int         slip;
    int         stray_at;
    int         random_reqs;
    bit         drain_marked;

    rst       = 1'b1;
    in_valid  = 1'b0;
    operation = i2cm_pkg::OP_TICK;
    data_byte = 8'h00;
    sda_in    = 1'b1;
    scl_in    = 1'b1;
    out_ready = 1'b0;
    m_cmd     = CMD_IDLE;
    m_phase   = '0;
    m_shift   = 8'h00;
    m_scl     = 1'b1;
    m_sda     = 1'b1;
    m_ack     = 1'b1;
    random_reqs  = 0;
    drain_marked = 1'b0;

    // tick while idle, unknown codes, probe on a busy bus
    push_req(i2cm_pkg::OP_TICK, 8'hFF, 1'b0, 1'b0);
    push_req(4'd9, 8'h00, 1'b1, 1'b1);
    push_req(4'd15, 8'hFF, 1'b0, 1'b1);
    push_req(i2cm_pkg::OP_PROBE, 8'hA0, 1'b0, 1'b1);
    push_req(i2cm_pkg::OP_PROBE, 8'hA0, 1'b1, 1'b0);
    // start with a command arriving mid-sequence
    push_req(i2cm_pkg::OP_START, 8'h00, 1'b1, 1'b1);
    push_req(i2cm_pkg::OP_TICK, 8'h00, 1'b1, 1'b1);
    push_req(i2cm_pkg::OP_WRITE, 8'h55, 1'b1, 1'b1);
    push_ticks(2);
    push_req(i2cm_pkg::OP_STOP, 8'h00, 1'b0, 1'b0);
    push_ticks(2);
    push_req(i2cm_pkg::OP_ACK, 8'h00, 1'b1, 1'b1);
    push_ticks(3);
    push_req(i2cm_pkg::OP_NACK, 8'h00, 1'b1, 1'b1);
    push_ticks(3);
    // wait ack sees an acknowledge
    push_req(i2cm_pkg::OP_WAIT, 8'h00, 1'b1, 1'b1);
    push_req(i2cm_pkg::OP_TICK, 8'h00, 1'b0, 1'b1);
    push_req(i2cm_pkg::OP_TICK, 8'h00, 1'b0, 1'b1);
    push_req(i2cm_pkg::OP_TICK, 8'h00, 1'b0, 1'b1);
    push_req(i2cm_pkg::OP_WRITE, 8'hFF, 1'b1, 1'b1);
    push_ticks(24);
    push_req(i2cm_pkg::OP_READ, 8'h00, 1'b1, 1'b1);
    for (int i = 0; i < 16; i++) push_req(i2cm_pkg::OP_TICK, 8'h00, i[1], 1'b1);
    push_req(i2cm_pkg::OP_PROBE, 8'h00, 1'b1, 1'b1);
    push_ticks(32);

    // random part: mostly whole sequences, some broken ones and noise
    while (random_reqs < RANDOM_REQS) begin
      kind = $urandom_range(0, 99);
      if (kind < 72) begin
        op = 4'($urandom_range(i2cm_pkg::OP_START, i2cm_pkg::OP_PROBE));
        case (op)
          i2cm_pkg::OP_STOP:  len = 2;
          i2cm_pkg::OP_WRITE: len = 24;
          i2cm_pkg::OP_READ:  len = 16;
          i2cm_pkg::OP_PROBE: len = 32;
          default:            len = 3;
        endcase
        case ($urandom_range(0, 9))
          0:       data = 8'h00;
          1:       data = 8'hFF;
          default: data = 8'($urandom);
        endcase
        // probe needs an idle bus to run
        if (op == i2cm_pkg::OP_PROBE) push_req(op, data, 1'b1, 1'b1);
        else push_req(op, data, 1'($urandom), 1'($urandom));
        slip     = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 4)) - 2 : 0;
        stray_at = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, len - 1)) : -1;
        for (int i = 0; i < len + slip; i++) begin
          if (i == stray_at) begin
            push_req(4'($urandom_range(i2cm_pkg::OP_START, i2cm_pkg::OP_PROBE)),
                     8'($urandom), 1'($urandom), 1'($urandom));
            random_reqs++;
          end
          push_ticks(1);
        end
        random_reqs += 1 + len + slip;
      end else if (kind < 82) begin
        push_req(i2cm_pkg::OP_PROBE, 8'($urandom), 1'($urandom), 1'($urandom));
        random_reqs++;
      end else if (kind < 90) begin
        push_req(4'($urandom_range(9, 15)), 8'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        push_ticks($urandom_range(1, 3));
      end
      // one pause of the sender until the block has drained
      if (!drain_marked && random_reqs >= 650) begin
        drain_marked = 1'b1;
        pending_reqs[pending_reqs.size() - 1].drain_first = 1'b1;
      end
    end
    total_reqs = pending_reqs.size();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (!(sent_count == total_reqs && due_results.size() == 0) &&
           cycle_count < CYCLE_LIMIT)
      @(posedge clk);

    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
    end else begin
      // let any stray result show up
      repeat (TAIL_CYCLES) @(posedge clk);
      if (error_count == 0) begin
        $display("Simulation PASSED");
      end else begin
        $display("Simulation FAILED");
      end
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_step.sv
hw/rtl/i2c_master_bit_engine.sv
bench/i2c_master_bit_engine_tb.sv
